// ----- rtl/scme_pkg.sv -----
// ----------------------------------------------------------------------------
// Sensor clamp, median and average package
// Shared widths, register reset values and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package scme_pkg;

  // Fixed field widths.
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned AVG_BITS    = 20;
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned WEIGHT_BITS = 17;
  localparam int unsigned CFG_IDX_BITS = 2;

  // Default depth of the median window.
  localparam int unsigned DEFAULT_WINDOW = 5;

  // Register reset values.
  localparam logic [SAMPLE_BITS-1:0] CLAMP_LOW_RST  = 12'd0;
  localparam logic [SAMPLE_BITS-1:0] CLAMP_HIGH_RST = 12'd4095;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RST     = 17'd6554;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE     = 17'd65536;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CLAMP_LOW  = 2'd0,
    CFG_CLAMP_HIGH = 2'd1,
    CFG_WEIGHT     = 2'd2
  } cfg_reg_e;

endpackage

`default_nettype wire

// ----- rtl/sensor_clamp_median_ema_core.sv -----
// ----------------------------------------------------------------------------
// Sensor clamp, median and moving average core
// An accepted sample is held in the input register and then loaded into the
// result register, from which its result is taken.
// Throughput: one sample per cycle while results drain; the compare-rank
// median and the single average multiplier both sit between the input and
// result registers. A waiting result with a full input register stalls input.
// Reset: control state, limits and weight return to their defaults at once.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_clamp_median_ema_core
  import scme_pkg::*;
#(
  parameter int unsigned WINDOW = DEFAULT_WINDOW
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,

  // Configuration writes, taken whenever the enable is high.
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [WEIGHT_BITS-1:0]  cfg_wdata_i,

  // Sample channel.
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0]  sample_i,

  // Result channel.
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [SAMPLE_BITS-1:0]       clamped_o,
  output logic [SAMPLE_BITS-1:0]       median_o,
  output logic [AVG_BITS-1:0]          smoothed_o
);

  localparam int unsigned PosW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned RankW = $clog2(WINDOW);
  localparam int unsigned Mid   = WINDOW / 2;
  localparam int unsigned ProdW = AVG_BITS + 1 + WEIGHT_BITS + 1;

  // --------------------------------------------------------------------------
  // Configuration registers. The user must issue writes only while the core is
  // idle, so processing always sees stable values; the core does not enforce it.
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] clamp_low_q;
  logic [SAMPLE_BITS-1:0] clamp_high_q;
  logic [WEIGHT_BITS-1:0] weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_low_q  <= CLAMP_LOW_RST;
      clamp_high_q <= CLAMP_HIGH_RST;
      weight_q     <= WEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CLAMP_LOW:  clamp_low_q  <= cfg_wdata_i[SAMPLE_BITS-1:0];
        CFG_CLAMP_HIGH: clamp_high_q <= cfg_wdata_i[SAMPLE_BITS-1:0];
        CFG_WEIGHT:     weight_q     <= cfg_wdata_i;
        default: begin
          // Writes to an unused index are dropped.
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. The input register holds an accepted sample; it moves into
  // the result register whenever that register is empty or being drained.
  // This lets a new transaction be accepted in every cycle while results
  // drain. When a result waits and the input register is full, the input
  // stalls.
  // --------------------------------------------------------------------------
  logic                   s1_valid_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic                   out_valid_q;
  logic                   advance;
  logic                   process;
  logic                   in_accept;

  assign advance    = !out_valid_q || out_ready_i;
  assign process    = advance && s1_valid_q;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_sample_q <= sample_i;
    end
  end

  // --------------------------------------------------------------------------
  // Filter state. The first sample fills the whole window and loads the
  // average directly; after that the window is a circular buffer.
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] window_q [WINDOW];
  logic [SAMPLE_BITS-1:0] window_d [WINDOW];
  logic [PosW-1:0]        wr_pos_q;
  logic [PosW-1:0]        wr_pos_d;
  logic                   first_q;
  logic [AVG_BITS-1:0]    avg_q;
  logic [AVG_BITS-1:0]    avg_d;

  // The window after this sample is written.
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      if (first_q || (wr_pos_q == PosW'(i))) begin
        window_d[i] = s1_sample_q;
      end else begin
        window_d[i] = window_q[i];
      end
    end
  end

  assign wr_pos_d = (wr_pos_q == PosW'(WINDOW - 1)) ? '0 : wr_pos_q + PosW'(1);

  // --------------------------------------------------------------------------
  // Median by ranking. Each entry counts the entries that sort before it,
  // with equal values ordered by position so every rank is unique. The entry
  // whose rank is the middle one is the median.
  // --------------------------------------------------------------------------
  logic [RankW-1:0]       rank   [WINDOW];
  logic [SAMPLE_BITS-1:0] median_d;

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if ((window_d[j] < window_d[i]) || ((window_d[j] == window_d[i]) && (j < i))) begin
          rank[i] = rank[i] + RankW'(1);
        end
      end
    end
  end

  always_comb begin
    median_d = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (rank[i] == RankW'(Mid)) begin
        median_d = median_d | window_d[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Moving average in Q12.8. The blend w*x + (1-w)*avg is rewritten as
  // avg + w*(x - avg), so a single signed multiplier does the work. The
  // arithmetic shift floors, which together with the half added before it
  // gives round to nearest with ties up.
  // --------------------------------------------------------------------------
  logic [WEIGHT_BITS-1:0]  weight_sat;
  logic [AVG_BITS-1:0]     sample_q12;
  logic signed [AVG_BITS:0]       avg_diff;
  logic signed [ProdW-1:0]        avg_prod;
  logic signed [ProdW-1:0]        avg_step;
  logic signed [ProdW-1:0]        avg_sum;

  assign weight_sat = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
  assign sample_q12 = AVG_BITS'({s1_sample_q, {FRAC_BITS{1'b0}}});
  assign avg_diff   = $signed({1'b0, sample_q12}) - $signed({1'b0, avg_q});
  assign avg_prod   = ProdW'(avg_diff) * $signed({1'b0, weight_sat});
  assign avg_step   = (avg_prod + ProdW'(1 << 15)) >>> 16;
  assign avg_sum    = $signed(ProdW'(avg_q)) + avg_step;
  assign avg_d      = first_q ? sample_q12 : avg_sum[AVG_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pos_q <= '0;
      first_q  <= 1'b1;
      avg_q    <= '0;
    end else if (process) begin
      wr_pos_q <= wr_pos_d;
      first_q  <= 1'b0;
      avg_q    <= avg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      for (int i = 0; i < WINDOW; i++) begin
        window_q[i] <= window_d[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Clamp. The lower limit applies first, so crossed limits give the upper
  // limit.
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] clamp_lo_c;
  logic [SAMPLE_BITS-1:0] clamped_d;

  assign clamp_lo_c = (s1_sample_q < clamp_low_q) ? clamp_low_q : s1_sample_q;
  assign clamped_d  = (clamp_lo_c > clamp_high_q) ? clamp_high_q : clamp_lo_c;

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] clamped_q;
  logic [SAMPLE_BITS-1:0] median_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      clamped_q <= clamped_d;
      median_q  <= median_d;
    end
  end

  // The running average register doubles as the smoothed output, since it
  // only changes when a new result is loaded.
  assign out_valid_o = out_valid_q;
  assign clamped_o   = clamped_q;
  assign median_o    = median_q;
  assign smoothed_o  = avg_q;

endmodule

`default_nettype wire

// ----- test/sensor_clamp_median_ema_checker.sv -----
// ----------------------------------------------------------------------------
// Sensor clamp, median and average checker
// Watches the configuration port and both channels of the core and keeps its
// own copy of the filter state. Every sample transaction queues the result
// that the core should give; every result transaction is compared with the
// oldest queued result, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_clamp_median_ema_checker
  import scme_pkg::*;
#(
  parameter int unsigned WINDOW = DEFAULT_WINDOW
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [WEIGHT_BITS-1:0]  cfg_wdata_i,
  input  wire logic                    in_valid_i,
  input  wire logic                    in_ready_i,
  input  wire logic [SAMPLE_BITS-1:0]  sample_i,
  input  wire logic                    out_valid_i,
  input  wire logic                    out_ready_i,
  input  wire logic [SAMPLE_BITS-1:0]  clamped_i,
  input  wire logic [SAMPLE_BITS-1:0]  median_i,
  input  wire logic [AVG_BITS-1:0]     smoothed_i,
  output int                           err_count_o,
  output int                           pending_o,
  output int                           results_o
);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] clamped;
    logic [SAMPLE_BITS-1:0] median;
    logic [AVG_BITS-1:0]    smoothed;
  } filter_out_t;

  // Shadow registers and filter state.
  logic [SAMPLE_BITS-1:0] lim_lo;
  logic [SAMPLE_BITS-1:0] lim_hi;
  logic [WEIGHT_BITS-1:0] weight;
  logic [SAMPLE_BITS-1:0] history [WINDOW];
  int unsigned            wr_pos;
  logic                   primed;
  logic [AVG_BITS-1:0]    avg;
  logic                   first_pending;

  filter_out_t expected_q [$];
  int errors = 0;
  int results = 0;

  // Advances the shadow filter by one sample and returns the result it gives.
  task automatic advance_filter(input logic [SAMPLE_BITS-1:0] s, output filter_out_t r);
    logic [SAMPLE_BITS-1:0] c;
    logic [SAMPLE_BITS-1:0] sorted [WINDOW];
    logic [SAMPLE_BITS-1:0] tmp;
    logic [WEIGHT_BITS-1:0] w;
    logic [63:0]            acc;
    c = s;
    if (c < lim_lo) c = lim_lo;
    if (c > lim_hi) c = lim_hi;

    // The very first sample fills the whole window so the median is defined.
    if (!primed && wr_pos == 0) begin
      for (int k = 0; k < WINDOW; k++) history[k] = s;
      primed = 1'b1;
    end
    history[wr_pos] = s;
    wr_pos = (wr_pos + 1) % WINDOW;

    if (first_pending) begin
      avg = {s, 8'h00};
      first_pending = 1'b0;
    end else begin
      w = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
      acc = 64'(w) * 64'({s, 8'h00}) + 64'(WEIGHT_ONE - w) * 64'(avg) + 64'd32768;
      avg = AVG_BITS'(acc >> 16);
    end

    sorted = history;
    for (int a = 1; a < WINDOW; a++) begin
      for (int b = a; b > 0 && sorted[b-1] > sorted[b]; b--) begin
        tmp         = sorted[b];
        sorted[b]   = sorted[b-1];
        sorted[b-1] = tmp;
      end
    end

    r.clamped  = c;
    r.median   = sorted[WINDOW/2];
    r.smoothed = avg;
  endtask

  task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    filter_out_t want;
    if (!rst_ni) begin
      lim_lo        = CLAMP_LOW_RST;
      lim_hi        = CLAMP_HIGH_RST;
      weight        = WEIGHT_RST;
      for (int k = 0; k < WINDOW; k++) history[k] = '0;
      wr_pos        = 0;
      primed        = 1'b0;
      avg           = '0;
      first_pending = 1'b1;
      expected_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        advance_filter(sample_i, want);
        expected_q.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        results++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result transaction with nothing expected, actual %0d/%0d/%0d",
                   $time, clamped_i, median_i, smoothed_i);
        end else begin
          want = expected_q.pop_front();
          compare_field("clamped", want.clamped, clamped_i);
          compare_field("median", want.median, median_i);
          compare_field("smoothed", want.smoothed, smoothed_i);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CLAMP_LOW:  lim_lo = cfg_wdata_i[SAMPLE_BITS-1:0];
          CFG_CLAMP_HIGH: lim_hi = cfg_wdata_i[SAMPLE_BITS-1:0];
          CFG_WEIGHT:     weight = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    pending_o   <= expected_q.size();
    err_count_o <= errors;
    results_o   <= results;
  end

endmodule

`default_nettype wire

// ----- test/tb_sensor_clamp_median_ema_core.sv -----
// ----------------------------------------------------------------------------
// Sensor clamp, median and average core testbench
// Drives samples and configuration writes into the core while a separate
// checker predicts every result. A short directed part covers the first
// sample, the limit extremes, crossed limits and the weight extremes; then
// random phases with random settings and random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sensor_clamp_median_ema_core;
  import scme_pkg::*;

  localparam int unsigned FILTER_WINDOW = DEFAULT_WINDOW;
  localparam int          LONG_STALL    = 300;
  localparam int          RAND_PHASES   = 12;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx = CFG_CLAMP_LOW;
  logic [WEIGHT_BITS-1:0]  cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [SAMPLE_BITS-1:0]  sample = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [SAMPLE_BITS-1:0]  clamped;
  logic [SAMPLE_BITS-1:0]  median;
  logic [AVG_BITS-1:0]     smoothed;

  int err_count;
  int pending;
  int results;

  // Stimulus state, owned by the main process.
  logic [SAMPLE_BITS-1:0] cur_lo = CLAMP_LOW_RST;
  logic [SAMPLE_BITS-1:0] cur_hi = CLAMP_HIGH_RST;
  logic [SAMPLE_BITS-1:0] last_sample = '0;
  logic                   tx_idle_en = 1'b1;
  int                     samples_sent = 0;
  int                     settings_used = 1;

  // Receiver controls. The main process only writes these with nonblocking
  // assignments; the receiver process owns its own stall counters.
  logic rx_idle_en = 1'b1;
  int   stall_req = 0;
  int   stall_seen = 0;
  int   hold_left = 0;

  always #2 clk = ~clk;

  sensor_clamp_median_ema_core #(
    .WINDOW (FILTER_WINDOW)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .sample_i    (sample),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .clamped_o   (clamped),
    .median_o    (median),
    .smoothed_o  (smoothed)
  );

  sensor_clamp_median_ema_checker #(
    .WINDOW (FILTER_WINDOW)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .sample_i    (sample),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .clamped_i   (clamped),
    .median_i    (median),
    .smoothed_i  (smoothed),
    .err_count_o (err_count),
    .pending_o   (pending),
    .results_o   (results)
  );

  // Gap lengths: mostly none, often one from the shorter of two ranges, now
  // and then one from the longer, so that pauses land on every pipeline phase.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Limits favor the two ends of the range.
  function automatic logic [SAMPLE_BITS-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r < 4) return '1;
    return SAMPLE_BITS'($urandom_range(0, 4095));
  endfunction

  // Weights include zero, one LSB, just under one, exactly one and values
  // above one that the core has to saturate.
  function automatic logic [WEIGHT_BITS-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return WEIGHT_ONE;
      2:       return '1;
      3:       return WEIGHT_BITS'(1);
      4:       return WEIGHT_ONE - 1;
      5:       return WEIGHT_RST;
      default: return WEIGHT_BITS'($urandom_range(0, 131071));
    endcase
  endfunction

  // Samples mix uniform values with values that sit right at the clamp
  // limits, full-scale extremes, repeated values (so the median window holds
  // duplicates) and single-bit patterns.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 4095);
      4:          v = $urandom_range(0, 1) ? 4095 : 0;
      5:          v = int'(cur_lo) + int'($urandom_range(0, 4)) - 2;
      6:          v = int'(cur_hi) + int'($urandom_range(0, 4)) - 2;
      7:          v = int'(last_sample);
      8: begin
        v = 1 << $urandom_range(0, SAMPLE_BITS - 1);
        if ($urandom_range(0, 1)) v = v ^ 4095;
      end
      default:    v = $urandom_range(0, 15);
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SAMPLE_BITS'(v);
  endfunction

  // Offers one sample and holds it until the core takes it. Valid stays high
  // between back-to-back samples; it only drops for a gap.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (!in_ready);
    last_sample = s;
    samples_sent++;
  endtask

  // Stops offering samples and waits until every queued result has come
  // back, then waits out a margin before touching the registers.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges while the core is idle.
  task automatic configure(input logic [SAMPLE_BITS-1:0] lo, input logic [SAMPLE_BITS-1:0] hi,
                           input logic [WEIGHT_BITS-1:0] w);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_CLAMP_LOW;
    cfg_wdata <= WEIGHT_BITS'(lo);
    @(posedge clk);
    cfg_idx   <= CFG_CLAMP_HIGH;
    cfg_wdata <= WEIGHT_BITS'(hi);
    @(posedge clk);
    cfg_idx   <= CFG_WEIGHT;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
    settings_used++;
  endtask

  // Receiver: random stalls while idling is enabled, and one long hold-off
  // each time the main process raises a stall request.
  always @(posedge clk) begin
    int len;
    if (stall_seen != stall_req) begin
      stall_seen = stall_req;
      hold_left  = LONG_STALL;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      len = rx_idle_en ? pick_gap() : 0;
      if (len > 0) begin
        hold_left = len - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #4000000;
    $display("%0t: timeout with %0d results still outstanding", $time, pending);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings. The first sample is full scale, so the whole window
    // and the average start there; then the samples swing between extremes.
    send_sample(12'd4095); send_sample(12'd0);    send_sample(12'd4095);
    send_sample(12'd0);    send_sample(12'd2048); send_sample(12'd1);
    send_sample(12'd4094);

    // Samples just outside and right on both limits, with a weight of one
    // so the average tracks the raw sample exactly.
    configure(12'd100, 12'd3000, WEIGHT_ONE);
    send_sample(12'd99);   send_sample(12'd100);  send_sample(12'd3000);
    send_sample(12'd3001); send_sample(12'd0);

    // Crossed limits: the output must sit at the upper limit. The weight is
    // at its largest code and must act as exactly one.
    configure(12'd3000, 12'd100, '1);
    send_sample(12'd50);   send_sample(12'd2000); send_sample(12'd4095);

    // Fully crossed limits and a zero weight, which freezes the average.
    configure(12'd4095, 12'd0, '0);
    send_sample(12'hAAA);  send_sample(12'h555);  send_sample(12'd4095);

    // Both limits at zero, smallest non-zero weight.
    configure(12'd0, 12'd0, WEIGHT_BITS'(1));
    send_sample(12'd1234); send_sample(12'd0);

    // Both limits at full scale, weight just under one.
    configure(12'd4095, 12'd4095, WEIGHT_ONE - 1);
    send_sample(12'd4095); send_sample(12'd0);    send_sample(12'd7);

    // Random phases. Every fourth phase runs without any idling on either
    // side; phase three holds the receiver off for a long stretch while the
    // sender keeps pushing, so the core fills up and drops its ready.
    for (int p = 0; p < RAND_PHASES; p++) begin
      configure(pick_limit(), pick_limit(), pick_weight());
      tx_idle_en = (p % 4 != 0);
      rx_idle_en <= (p % 4 != 0);
      if (p == 3) begin
        tx_idle_en = 1'b0;
        stall_req <= stall_req + 1;
      end
      n = $urandom_range(120, 180);
      repeat (n) send_sample(pick_sample());
    end

    drain();
    repeat (4) @(posedge clk);

    $display("Covered %0d samples and %0d results under %0d register settings,",
             samples_sent, results, settings_used);
    $display("including crossed limits, saturated weights and a long output hold-off.");
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/scme_pkg.sv
rtl/sensor_clamp_median_ema_core.sv
test/sensor_clamp_median_ema_checker.sv
test/tb_sensor_clamp_median_ema_core.sv
